FILE: rtl/assert_macros.svh
// assertion helpers shared by the key event classifier modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property checked while out of reset
`define KPEC_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("kpec check failed");
// property checked on every edge, reset included
`define KPEC_ASSERT_RST(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("kpec reset check failed");
`else
`define KPEC_ASSERT(lbl, clk, rstn, prop)
`define KPEC_ASSERT_RST(lbl, clk, prop)
`endif
`endif

FILE: rtl/kpec_pkg.sv
package kpec_pkg;

    localparam int KPEC_SLOTS    = 8;
    localparam int KPEC_NUM_KEYS = 8;
    localparam int KPEC_CNT_W    = 16;
    localparam int KPEC_GAP_W    = 8;
    localparam int KPEC_IDX_W    = 3;
    localparam int KPEC_DATA_W   = 16;

    // configuration register indexes
    typedef enum logic [KPEC_IDX_W-1:0] {
        CFG_KEY_ENABLE   = 3'd0,
        CFG_DOUBLE_CLICK = 3'd1,
        CFG_SCAN_TICKS   = 3'd2,
        CFG_LONG_TICKS   = 3'd3,
        CFG_UP_TICKS     = 3'd4,
        CFG_TWICE_TICKS  = 3'd5
    } t_cfg_reg;

    typedef struct packed {
        logic [KPEC_CNT_W-1:0] scan_ticks;
        logic [KPEC_CNT_W-1:0] long_ticks;
        logic [KPEC_CNT_W-1:0] up_ticks;
        logic [KPEC_GAP_W-1:0] twice_ticks;
    } t_lane_cfg;

    typedef struct packed {
        logic short_press;
        logic short_release;
        logic long_press;
        logic long_release;
        logic double_click;
    } t_key_events;

    typedef struct packed {
        logic [KPEC_SLOTS-1:0] short_press;
        logic [KPEC_SLOTS-1:0] short_release;
        logic [KPEC_SLOTS-1:0] long_press;
        logic [KPEC_SLOTS-1:0] long_release;
        logic [KPEC_SLOTS-1:0] double_click;
    } t_key_result;

endpackage

FILE: rtl/kpec_in_if.sv
interface kpec_in_if import kpec_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [KPEC_SLOTS-1:0] pressed_keys;

    modport src (output valid, output pressed_keys, input ready);
    modport snk (input valid, input pressed_keys, output ready);
endinterface

FILE: rtl/kpec_out_if.sv
interface kpec_out_if import kpec_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [KPEC_SLOTS-1:0] short_press;
    logic [KPEC_SLOTS-1:0] short_release;
    logic [KPEC_SLOTS-1:0] long_press;
    logic [KPEC_SLOTS-1:0] long_release;
    logic [KPEC_SLOTS-1:0] double_click;

    modport src (output valid, output short_press, output short_release, output long_press,
                 output long_release, output double_click, input ready);
    modport snk (input valid, input short_press, input short_release, input long_press,
                 input long_release, input double_click, output ready);
endinterface

FILE: rtl/kpec_lane.sv
`include "assert_macros.svh"

module kpec_lane import kpec_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step,
    input  logic        i_level,
    input  logic        i_dbl,
    input  t_lane_cfg   i_cfg,
    output t_key_events o_ev
);

    logic [KPEC_CNT_W-1:0] r_held, n_held, r_chg, n_chg, held_inc;
    logic [KPEC_GAP_W-1:0] r_pg, n_pg, r_rg, n_rg, pg_inc, rg_inc;
    logic                  r_stable, n_stable, r_pp, n_pp, r_rp, n_rp, r_ds, n_ds;

    always_comb begin
        pg_inc   = (r_pg != '1) ? r_pg + KPEC_GAP_W'(1) : r_pg;
        rg_inc   = (r_rg != '1) ? r_rg + KPEC_GAP_W'(1) : r_rg;
        held_inc = (r_held != '1) ? r_held + KPEC_CNT_W'(1) : r_held;
        n_held   = r_held;
        n_chg    = r_chg;
        n_stable = r_stable;
        n_pg     = pg_inc;
        n_rg     = rg_inc;
        n_pp     = r_pp;
        n_rp     = r_rp;
        n_ds     = r_ds;
        o_ev     = '0;
        if (!i_level || !r_stable) begin
            // level differs from the debounced one, or key released
            if (r_chg < i_cfg.up_ticks) begin
                n_chg = r_chg + KPEC_CNT_W'(1);
            end else begin
                if (r_held >= i_cfg.long_ticks) begin
                    n_ds = 1'b0;
                    o_ev.long_release = 1'b1;
                end else if (r_held >= i_cfg.scan_ticks) begin
                    if (i_dbl) begin
                        if (r_ds) begin
                            n_ds = 1'b0;
                        end else begin
                            if (r_rp) o_ev.short_release = 1'b1;
                            n_rg = '0;
                            n_rp = 1'b1;
                        end
                    end else begin
                        o_ev.short_release = 1'b1;
                    end
                end
                n_stable = i_level;
                n_held   = '0;
            end
        end else begin
            n_held = held_inc;
            if (held_inc == i_cfg.scan_ticks) begin
                n_chg = '0;
                if (i_dbl) begin
                    if (r_rp && pg_inc < i_cfg.twice_ticks) begin
                        n_ds = 1'b1;
                        n_rp = 1'b0;
                        n_pp = 1'b0;
                        o_ev.double_click = 1'b1;
                    end else begin
                        n_ds = 1'b0;
                        n_pp = 1'b1;
                        n_pg = '0;
                    end
                end else begin
                    o_ev.short_press = 1'b1;
                end
            end else if (held_inc == i_cfg.long_ticks) begin
                n_ds = 1'b0;
                o_ev.long_press = 1'b1;
            end
        end
        // deferred single events once the double-click window closes
        if (i_dbl) begin
            if (n_pp && n_pg >= i_cfg.twice_ticks) begin
                n_pp = 1'b0;
                o_ev.short_press = 1'b1;
            end
            if (n_rp && n_rg >= i_cfg.twice_ticks) begin
                n_rp = 1'b0;
                o_ev.short_release = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held   <= '0;
            r_chg    <= '0;
            r_stable <= 1'b0;
            r_pg     <= '0;
            r_rg     <= '0;
            r_pp     <= 1'b0;
            r_rp     <= 1'b0;
            r_ds     <= 1'b0;
        end else if (i_step) begin
            r_held   <= n_held;
            r_chg    <= n_chg;
            r_stable <= n_stable;
            r_pg     <= n_pg;
            r_rg     <= n_rg;
            r_pp     <= n_pp;
            r_rp     <= n_rp;
            r_ds     <= n_ds;
        end
    end

    // a released key never accumulates held time
    `KPEC_ASSERT(a_held_needs_press, i_clk, i_rst_n, (r_held != '0) |-> r_stable)
    // a double click consumes both pending single events
    `KPEC_ASSERT(a_dc_ends_pending, i_clk, i_rst_n, i_step && o_ev.double_click |=> !(r_pp || r_rp))

endmodule

FILE: rtl/kpec_merge.sv
`include "assert_macros.svh"

module kpec_merge import kpec_pkg::*; #(
    parameter int NUM_KEYS = KPEC_NUM_KEYS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  t_key_events           i_ev [KPEC_SLOTS],
    input  logic [KPEC_SLOTS-1:0] i_enable,
    output logic                  o_ready,
    kpec_out_if.src               o_event
);

    t_key_result res;
    t_key_result r_q [2];
    logic        r_wr, r_rd;
    logic [1:0]  r_count, n_count;
    logic        pop;

    // gather lane findings into per-event masks
    always_comb begin
        res = '0;
        for (int k = 0; k < KPEC_SLOTS; k++) begin
            if (k < NUM_KEYS) begin
                res.short_press[k]   = i_ev[k].short_press;
                res.short_release[k] = i_ev[k].short_release;
                res.long_press[k]    = i_ev[k].long_press;
                res.long_release[k]  = i_ev[k].long_release;
                res.double_click[k]  = i_ev[k].double_click;
            end
        end
        res.short_press   = res.short_press & i_enable;
        res.short_release = res.short_release & i_enable;
        res.long_press    = res.long_press & i_enable;
        res.long_release  = res.long_release & i_enable;
        res.double_click  = res.double_click & i_enable;
    end

    assign o_ready = (r_count != 2'd2);
    assign pop     = o_event.valid && o_event.ready;

    always_comb begin
        n_count = r_count;
        if (i_push && !pop) n_count = r_count + 2'd1;
        else if (!i_push && pop) n_count = r_count - 2'd1;
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_q[r_wr] <= res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) r_wr <= ~r_wr;
            if (pop) r_rd <= ~r_rd;
            r_count <= n_count;
        end
    end

    assign o_event.valid         = (r_count != 2'd0);
    assign o_event.short_press   = r_q[r_rd].short_press;
    assign o_event.short_release = r_q[r_rd].short_release;
    assign o_event.long_press    = r_q[r_rd].long_press;
    assign o_event.long_release  = r_q[r_rd].long_release;
    assign o_event.double_click  = r_q[r_rd].double_click;

    `KPEC_ASSERT(a_count_range, i_clk, i_rst_n, r_count != 2'd3)
    `KPEC_ASSERT(a_fill_to_full, i_clk, i_rst_n, (i_push && !pop && r_count == 2'd1) |=> !o_ready)
    `KPEC_ASSERT_RST(a_reset_empty, i_clk, !i_rst_n |=> !o_event.valid)

endmodule

FILE: rtl/key_press_event_classifier_top.sv
// key press event classifier
// i_scan carries one transaction per scan tick: pressed_keys holds the raw level of every
// key. each tick runs one debounce and press qualifier per key, all keys side by side, and
// gives exactly one transaction on o_event holding the short press, short release, long
// press, long release and double click masks of that tick.
// an accepted tick's result is registered in the output queue; a tick can be accepted
// every cycle the queue has room, as all per-key state updates in the cycle of acceptance.
// a two-entry output queue parts the channels: i_scan.ready stays high while the queue
// has room, so one result may wait on a stalled receiver while the next tick is taken;
// with both entries waiting, i_scan.ready drops until o_event.ready takes one.
// configuration is written through i_cfg_we / i_cfg_idx / i_cfg_wdata, one register per
// cycle; unknown indexes are ignored. the user must write it only while no tick is in
// flight (not enforced by the block). synchronous reset clears all per-key counters and
// flags, empties the queue and loads the default registers: no keys enabled, short press at
// 3 ticks, long press at 100, debounce of 3 ticks and a double-click window of 30 ticks.
module key_press_event_classifier_top import kpec_pkg::*; #(
    parameter int NUM_KEYS = KPEC_NUM_KEYS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [KPEC_IDX_W-1:0]  i_cfg_idx,
    input  logic [KPEC_DATA_W-1:0] i_cfg_wdata,
    kpec_in_if.snk                 i_scan,
    kpec_out_if.src                o_event
);

    logic [KPEC_SLOTS-1:0] r_key_enable;
    logic [KPEC_SLOTS-1:0] r_dbl_enable;
    t_lane_cfg             r_lane_cfg;

    logic                  accept;
    logic                  merge_ready;
    logic [KPEC_SLOTS-1:0] level_mask;
    logic [KPEC_SLOTS-1:0] dbl_mask;
    t_key_events           lane_ev [KPEC_SLOTS];

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_enable           <= '0;
            r_dbl_enable           <= '0;
            r_lane_cfg.scan_ticks  <= KPEC_CNT_W'(3);
            r_lane_cfg.long_ticks  <= KPEC_CNT_W'(100);
            r_lane_cfg.up_ticks    <= KPEC_CNT_W'(3);
            r_lane_cfg.twice_ticks <= KPEC_GAP_W'(30);
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                CFG_KEY_ENABLE:   r_key_enable           <= i_cfg_wdata[KPEC_SLOTS-1:0];
                CFG_DOUBLE_CLICK: r_dbl_enable           <= i_cfg_wdata[KPEC_SLOTS-1:0];
                CFG_SCAN_TICKS:   r_lane_cfg.scan_ticks  <= i_cfg_wdata;
                CFG_LONG_TICKS:   r_lane_cfg.long_ticks  <= i_cfg_wdata;
                CFG_UP_TICKS:     r_lane_cfg.up_ticks    <= i_cfg_wdata;
                CFG_TWICE_TICKS:  r_lane_cfg.twice_ticks <= i_cfg_wdata[KPEC_GAP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // disabled keys read as released and without double click
    assign level_mask    = i_scan.pressed_keys & r_key_enable;
    assign dbl_mask      = r_dbl_enable & r_key_enable;
    assign i_scan.ready  = merge_ready;
    assign accept        = i_scan.valid && merge_ready;

    // one qualifier lane per key
    for (genvar k = 0; k < KPEC_SLOTS; k++) begin : g_lane
        if (k < NUM_KEYS) begin : g_on
            kpec_lane u_lane (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_step  (accept),
                .i_level (level_mask[k]),
                .i_dbl   (dbl_mask[k]),
                .i_cfg   (r_lane_cfg),
                .o_ev    (lane_ev[k])
            );
        end else begin : g_off
            assign lane_ev[k] = '0;
        end
    end

    // merge lane events into the result masks and queue them
    kpec_merge #(
        .NUM_KEYS (NUM_KEYS)
    ) u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (accept),
        .i_ev     (lane_ev),
        .i_enable (r_key_enable),
        .o_ready  (merge_ready),
        .o_event  (o_event)
    );

endmodule

FILE: tb/sv/key_press_event_classifier_top_tb.sv
module key_press_event_classifier_top_tb;
    import kpec_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 250000;
    localparam int unsigned REPORT_LIMIT = 10;
    localparam int unsigned RUN_CAP      = 300;
    localparam int unsigned PHASES       = 9;

    // indexes past the last register, writes there must be dropped
    localparam logic [KPEC_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [KPEC_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    // ------------------------------------------------------------------
    // scoreboard: per-key qualifier model plus queue of expected masks
    // ------------------------------------------------------------------
    class key_event_scoreboard;
        logic [KPEC_SLOTS-1:0] enable_mask;
        logic [KPEC_SLOTS-1:0] dbl_mask;
        t_lane_cfg             lane_cfg;

        logic [KPEC_CNT_W-1:0] held_ticks     [KPEC_SLOTS];
        logic [KPEC_CNT_W-1:0] change_ticks   [KPEC_SLOTS];
        logic                  stable_pressed [KPEC_SLOTS];
        logic [KPEC_GAP_W-1:0] press_gap      [KPEC_SLOTS];
        logic [KPEC_GAP_W-1:0] release_gap    [KPEC_SLOTS];
        logic                  press_waiting  [KPEC_SLOTS];
        logic                  release_waiting[KPEC_SLOTS];
        logic                  double_done    [KPEC_SLOTS];

        t_key_result           expected_events[$];
        int unsigned           ticks_noted;
        int unsigned           results_seen;
        int unsigned           mismatches;
        int unsigned           event_bits[5];

        function new();
            enable_mask          = '0;
            dbl_mask             = '0;
            lane_cfg.scan_ticks  = 16'd3;
            lane_cfg.long_ticks  = 16'd100;
            lane_cfg.up_ticks    = 16'd3;
            lane_cfg.twice_ticks = 8'd30;
            for (int k = 0; k < KPEC_SLOTS; k++) begin
                held_ticks[k]      = '0;
                change_ticks[k]    = '0;
                stable_pressed[k]  = 1'b0;
                press_gap[k]       = '0;
                release_gap[k]     = '0;
                press_waiting[k]   = 1'b0;
                release_waiting[k] = 1'b0;
                double_done[k]     = 1'b0;
            end
            ticks_noted  = 0;
            results_seen = 0;
            mismatches   = 0;
            for (int e = 0; e < 5; e++) event_bits[e] = 0;
        endfunction

        function void load_register(logic [KPEC_IDX_W-1:0] idx, logic [KPEC_DATA_W-1:0] data);
            case (idx)
                CFG_KEY_ENABLE:   enable_mask          = data[KPEC_SLOTS-1:0];
                CFG_DOUBLE_CLICK: dbl_mask             = data[KPEC_SLOTS-1:0];
                CFG_SCAN_TICKS:   lane_cfg.scan_ticks  = data;
                CFG_LONG_TICKS:   lane_cfg.long_ticks  = data;
                CFG_UP_TICKS:     lane_cfg.up_ticks    = data;
                CFG_TWICE_TICKS:  lane_cfg.twice_ticks = data[KPEC_GAP_W-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned pending();
            return expected_events.size();
        endfunction

        // one scan tick: advance every key and queue the event masks it gives
        function void note_scan_tick(logic [KPEC_SLOTS-1:0] keys);
            t_key_result           ev;
            logic [KPEC_SLOTS-1:0] levels;
            logic [KPEC_SLOTS-1:0] dbl_keys;
            logic                  lvl;
            logic                  dbl;
            ev       = '0;
            levels   = keys & enable_mask;
            dbl_keys = dbl_mask & enable_mask;
            for (int k = 0; k < KPEC_NUM_KEYS; k++) begin
                lvl = levels[k];
                dbl = dbl_keys[k];
                if (press_gap[k] != '1) press_gap[k]++;
                if (release_gap[k] != '1) release_gap[k]++;

                if (!lvl || lvl != stable_pressed[k]) begin
                    if (change_ticks[k] < lane_cfg.up_ticks) begin
                        change_ticks[k]++;
                    end else begin
                        // level change accepted, classify what was held
                        if (held_ticks[k] >= lane_cfg.long_ticks) begin
                            double_done[k]     = 1'b0;
                            ev.long_release[k] = 1'b1;
                        end else if (held_ticks[k] >= lane_cfg.scan_ticks) begin
                            if (dbl) begin
                                if (double_done[k]) begin
                                    double_done[k] = 1'b0;
                                end else begin
                                    if (release_waiting[k]) ev.short_release[k] = 1'b1;
                                    release_gap[k]     = '0;
                                    release_waiting[k] = 1'b1;
                                end
                            end else begin
                                ev.short_release[k] = 1'b1;
                            end
                        end
                        stable_pressed[k] = lvl;
                        held_ticks[k]     = '0;
                    end
                end else begin
                    if (held_ticks[k] != '1) held_ticks[k]++;
                    if (held_ticks[k] == lane_cfg.scan_ticks) begin
                        change_ticks[k] = '0;
                        if (dbl) begin
                            if (release_waiting[k] && press_gap[k] < lane_cfg.twice_ticks) begin
                                double_done[k]     = 1'b1;
                                release_waiting[k] = 1'b0;
                                press_waiting[k]   = 1'b0;
                                ev.double_click[k] = 1'b1;
                            end else begin
                                double_done[k]   = 1'b0;
                                press_waiting[k] = 1'b1;
                                press_gap[k]     = '0;
                            end
                        end else begin
                            ev.short_press[k] = 1'b1;
                        end
                    end else if (held_ticks[k] == lane_cfg.long_ticks) begin
                        double_done[k]   = 1'b0;
                        ev.long_press[k] = 1'b1;
                    end
                end

                // deferred single events come out once the window has run out
                if (dbl) begin
                    if (press_waiting[k] && press_gap[k] >= lane_cfg.twice_ticks) begin
                        press_waiting[k]  = 1'b0;
                        ev.short_press[k] = 1'b1;
                    end
                    if (release_waiting[k] && release_gap[k] >= lane_cfg.twice_ticks) begin
                        release_waiting[k]  = 1'b0;
                        ev.short_release[k] = 1'b1;
                    end
                end
            end
            ev.short_press   &= enable_mask;
            ev.short_release &= enable_mask;
            ev.long_press    &= enable_mask;
            ev.long_release  &= enable_mask;
            ev.double_click  &= enable_mask;
            expected_events.push_back(ev);
            ticks_noted++;
        endfunction

        function void check_event(t_key_result got);
            t_key_result want;
            results_seen++;
            event_bits[0] += $countones(got.short_press);
            event_bits[1] += $countones(got.short_release);
            event_bits[2] += $countones(got.long_press);
            event_bits[3] += $countones(got.long_release);
            event_bits[4] += $countones(got.double_click);
            if (expected_events.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("result %0d unexpected: sp %h sr %h lp %h lr %h dc %h",
                             results_seen, got.short_press, got.short_release, got.long_press,
                             got.long_release, got.double_click);
                return;
            end
            want = expected_events.pop_front();
            if (got.short_press !== want.short_press || got.short_release !== want.short_release ||
                got.long_press !== want.long_press || got.long_release !== want.long_release ||
                got.double_click !== want.double_click) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("result %0d: expected sp %h sr %h lp %h lr %h dc %h",
                             results_seen, want.short_press, want.short_release,
                             want.long_press, want.long_release, want.double_click);
                    $display("           actual   sp %h sr %h lp %h lr %h dc %h",
                             got.short_press, got.short_release, got.long_press,
                             got.long_release, got.double_click);
                end
            end
        endfunction
    endclass

    // ------------------------------------------------------------------
    // register settings, one per phase of the run
    // ------------------------------------------------------------------
    typedef struct packed {
        logic [7:0]  key_enable;
        logic [7:0]  double_keys;
        logic [15:0] scan_ticks;
        logic [15:0] long_ticks;
        logic [15:0] up_ticks;
        logic [7:0]  twice_ticks;
        logic [15:0] tick_count;
    } t_phase_setting;

    t_phase_setting phase_plan [PHASES] = '{
        '{8'hFF, 8'h00, 16'd2,    16'd8,    16'd1,    8'd6,   16'd200}, // plain single events
        '{8'hFF, 8'hFF, 16'd2,    16'd10,   16'd1,    8'd8,   16'd300}, // double click on every key
        '{8'hA5, 8'h3C, 16'd3,    16'd12,   16'd2,    8'd10,  16'd250}, // part masked, mixed modes
        '{8'hFF, 8'h0F, 16'd1,    16'd1,    16'd0,    8'd1,   16'd150}, // lowest legal, scan == long
        '{8'hFF, 8'hF0, 16'd4,    16'd4,    16'd3,    8'd255, 16'd250}, // equal thresholds, wide window
        '{8'h7E, 8'h55, 16'd0,    16'd0,    16'd0,    8'd0,   16'd100}, // zero thresholds taken literally
        '{8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd255, 16'd60},  // top of every range
        '{8'h00, 8'hFF, 16'd2,    16'd6,    16'd1,    8'd5,   16'd60},  // no key enabled
        '{8'hFF, 8'hAA, 16'd3,    16'd100,  16'd3,    8'd30,  16'd200}  // reset threshold values
    };

    // directed opening: all released, all pressed, alternating and half patterns
    logic [7:0] directed_keys [19] = '{
        8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h55, 8'h55, 8'h55,
        8'hAA, 8'hAA, 8'hAA, 8'h0F, 8'h0F, 8'hF0, 8'hF0, 8'h00, 8'h00
    };

    // ------------------------------------------------------------------
    // clock, reset, block under test
    // ------------------------------------------------------------------
    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [KPEC_IDX_W-1:0]  i_cfg_idx;
    logic [KPEC_DATA_W-1:0] i_cfg_wdata;

    kpec_in_if  scan_if ();
    kpec_out_if event_if ();

    key_press_event_classifier_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_scan      (scan_if),
        .o_event     (event_if)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    key_event_scoreboard sb;
    int unsigned         cycle_count = 0;
    int unsigned         sender_calm = 0;
    int unsigned         receiver_calm = 0;
    int unsigned         phases_run = 0;
    int unsigned         run_left [KPEC_SLOTS];
    logic                run_level [KPEC_SLOTS];

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // wait cycles before the next transaction, with calm stretches of no waiting at all
    function automatic int unsigned draw_wait(ref int unsigned calm_left);
        if (calm_left != 0) begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            calm_left = $urandom_range(20, 60);
            return 0;
        end
        return $urandom_range(0, 5);
    endfunction

    // length of the next run of one level, sized from the current thresholds
    function automatic int unsigned run_length(logic pressed);
        int unsigned up;
        int unsigned scan;
        int unsigned lng;
        int unsigned twice;
        int unsigned pick;
        int unsigned lo;
        int unsigned hi;
        up    = sb.lane_cfg.up_ticks;
        scan  = sb.lane_cfg.scan_ticks;
        lng   = sb.lane_cfg.long_ticks;
        twice = sb.lane_cfg.twice_ticks;
        pick  = $urandom_range(0, 9);
        if (pressed) begin
            if (pick < 2) begin
                // bounce shorter than the debounce
                lo = 1;
                hi = up + 1;
            end else if (pick < 7) begin
                // held past short press but not to long press
                lo = scan + up + 1;
                hi = ((lng > scan) ? lng - 1 : scan) + up + 1;
            end else begin
                lo = lng + up + 1;
                hi = lng + up + 9;
            end
        end else begin
            if (pick < 3) begin
                lo = 1;
                hi = up + 1;
            end else if (pick < 7) begin
                // gap short enough for a second click
                lo = up + 1;
                hi = up + twice + 1;
            end else begin
                lo = up + twice;
                hi = up + twice + 40;
            end
        end
        if (hi > RUN_CAP) hi = RUN_CAP;
        if (lo > hi) lo = hi;
        if (lo == 0) lo = 1;
        if (hi == 0) hi = 1;
        return $urandom_range(lo, hi);
    endfunction

    // mostly well-formed press and release runs per key, plus bounce noise
    function automatic logic [7:0] next_keys();
        logic [7:0] keys;
        for (int k = 0; k < KPEC_SLOTS; k++) begin
            if (run_left[k] == 0) begin
                run_level[k] = ~run_level[k];
                run_left[k]  = run_length(run_level[k]);
            end
            run_left[k]--;
            keys[k] = run_level[k];
        end
        if ($urandom_range(0, 19) == 0) keys ^= 8'($urandom) & 8'($urandom);
        if ($urandom_range(0, 31) == 0) keys = 8'($urandom);
        return keys;
    endfunction

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------
    task automatic wait_for_drain();
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    task automatic send_tick(input logic [7:0] keys, input bit hold_off);
        int unsigned gap;
        gap = draw_wait(sender_calm);
        if (gap != 0 || hold_off) begin
            scan_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            // hold the next tick back until the block has emptied
            if (hold_off) wait_for_drain();
        end
        scan_if.valid        <= 1'b1;
        scan_if.pressed_keys <= keys;
        @(posedge i_clk);
        while (!scan_if.ready) @(posedge i_clk);
        sb.note_scan_tick(keys);
    endtask

    // write enable stays high across a burst, caller lowers it
    task automatic program_reg(input logic [KPEC_IDX_W-1:0]  idx,
                               input logic [KPEC_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        sb.load_register(idx, data);
    endtask

    // result side: random stalls, every accepted transaction goes to the scoreboard
    initial begin
        t_key_result got;
        int unsigned stall;
        event_if.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            stall = draw_wait(receiver_calm);
            if (stall != 0) begin
                event_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            event_if.ready <= 1'b1;
            @(posedge i_clk);
            while (!event_if.valid) @(posedge i_clk);
            got.short_press   = event_if.short_press;
            got.short_release = event_if.short_release;
            got.long_press    = event_if.long_press;
            got.long_release  = event_if.long_release;
            got.double_click  = event_if.double_click;
            sb.check_event(got);
        end
    end

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        t_phase_setting ph;
        sb = new();
        for (int k = 0; k < KPEC_SLOTS; k++) begin
            run_left[k]  = $urandom_range(0, 8);
            run_level[k] = 1'b0;
        end
        i_rst_n              <= 1'b0;
        i_cfg_we             <= 1'b0;
        i_cfg_idx            <= '0;
        i_cfg_wdata          <= '0;
        scan_if.valid        <= 1'b0;
        scan_if.pressed_keys <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int p = 0; p < PHASES; p++) begin
            ph = phase_plan[p];
            // wait until the block is idle, with nothing in flight
            if (p != 0) begin
                scan_if.valid <= 1'b0;
                wait_for_drain();
                repeat (2) @(posedge i_clk);
            end
            // spare index first, its write must change nothing
            program_reg(p[0] ? CFG_SPARE_HI : CFG_SPARE_LO, 16'($urandom));
            // upper data bits of the narrow registers are junk on purpose
            program_reg(CFG_KEY_ENABLE,   {8'($urandom), ph.key_enable});
            program_reg(CFG_DOUBLE_CLICK, {8'($urandom), ph.double_keys});
            program_reg(CFG_SCAN_TICKS,   ph.scan_ticks);
            program_reg(CFG_LONG_TICKS,   ph.long_ticks);
            program_reg(CFG_UP_TICKS,     ph.up_ticks);
            program_reg(CFG_TWICE_TICKS,  {8'($urandom), ph.twice_ticks});
            i_cfg_we <= 1'b0;
            phases_run++;

            if (p == 0) begin
                foreach (directed_keys[d]) send_tick(directed_keys[d], 1'b0);
            end
            for (int n = 0; n < ph.tick_count; n++)
                send_tick(next_keys(), $urandom_range(0, 149) == 0);
        end

        // all ticks in, let the last results come out
        scan_if.valid <= 1'b0;
        wait_for_drain();
        repeat (4) @(posedge i_clk);

        $display("covered %0d scan ticks under %0d register settings, %0d results checked",
                 sb.ticks_noted, phases_run, sb.results_seen);
        $display("event bits seen: sp %0d, sr %0d, lp %0d, lr %0d, dc %0d",
                 sb.event_bits[0], sb.event_bits[1], sb.event_bits[2], sb.event_bits[3],
                 sb.event_bits[4]);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("%0d mismatches, %0d results still expected", sb.mismatches, sb.pending());
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

FILE: key_press_event_classifier_top.f
+incdir+rtl
rtl/kpec_pkg.sv
rtl/kpec_in_if.sv
rtl/kpec_out_if.sv
rtl/kpec_lane.sv
rtl/kpec_merge.sv
rtl/key_press_event_classifier_top.sv
tb/sv/key_press_event_classifier_top_tb.sv
